FILE: sv/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg: shared definitions for the wildcard signature scanner
// Sizes, widths, configuration register codes and the types that travel
// between the top level, the cell chain and the cells.
// ----------------------------------------------------------------------------
package wss_pkg;

	// Window depth in bytes and the longest pattern that can be used.
	localparam int WINDOW  = 32;
	localparam int PAT_LEN = 16;
	localparam int MAX_LEN = (PAT_LEN < WINDOW) ? PAT_LEN : WINDOW;

	// Pattern bytes held by the configuration registers.
	localparam int PAT_REG_BYTES = 16;

	// Widths derived from the sizes above.
	localparam int AGE_W  = $clog2(WINDOW);
	localparam int SPAN_W = $clog2(WINDOW + 1);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int IDX_W  = $clog2(MAX_LEN);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW     = 3'd0,
		REG_PATTERN_HIGH    = 3'd1,
		REG_CARE_MASK       = 3'd2,
		REG_PATTERN_LENGTH  = 3'd3,
		REG_RETURN_MODE     = 3'd4,
		REG_POINTER_OFFSET  = 3'd5,
		REG_ADDRESS_ADJUST  = 3'd6,
		REG_IMAGE_BASE      = 3'd7
	} cfg_reg_t;

	// Return mode codes.
	localparam logic MODE_POINTER = 1'b0;
	localparam logic MODE_ADDRESS = 1'b1;

	// Result status codes.
	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	// Post-shift view of the window, index 0 is the newest byte.
	typedef logic [WINDOW-1:0][7:0] win_t;

	// Match settings handed to every cell.
	typedef struct packed {
		logic [MAX_LEN-1:0][7:0] pattern;
		logic [MAX_LEN-1:0]      care;
		logic [LEN_W-1:0]        len;
		logic [SPAN_W-1:0]       span;
	} mcfg_t;

endpackage

FILE: sv/wss_cell.sv
// ----------------------------------------------------------------------------
// wss_cell: one window cell
// Holds one image byte, passes it on to the next older cell on every shift,
// and checks the byte it is about to take against the pattern byte that
// lines up with its place in the window.
// ----------------------------------------------------------------------------
module wss_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [wss_pkg::AGE_W-1:0]  age,
	input  wss_pkg::mcfg_t             mcfg,
	input  logic [7:0]                 byte_in,
	output logic [7:0]                 byte_q,
	output logic                       ok
);
	import wss_pkg::*;

	logic [SPAN_W-1:0] age_ext;
	logic [SPAN_W-1:0] rel;
	logic              active;
	logic [IDX_W-1:0]  pat_idx;

	// Pattern byte index for this cell: span - 1 - age, in use when below len.
	always_comb begin
		age_ext = SPAN_W'(age);
		rel     = mcfg.span - SPAN_W'(1) - age_ext;
		active  = (age_ext < mcfg.span) && (rel < SPAN_W'(mcfg.len));
		pat_idx = rel[IDX_W-1:0];
	end

	// A cell outside the tested span, or under a wildcard, always agrees.
	assign ok = !active || !mcfg.care[pat_idx] || (byte_in == mcfg.pattern[pat_idx]);

	// Byte storage.
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

FILE: sv/wss_chain.sv
// ----------------------------------------------------------------------------
// wss_chain: row of window cells
// The newest image byte enters cell 0 and every byte moves one cell older
// on every shift. Gives the post-shift window and the combined pattern
// check of all cells.
// ----------------------------------------------------------------------------
module wss_chain (
	input  logic            clk,
	input  logic            shift,
	input  logic [7:0]      data_byte,
	input  wss_pkg::mcfg_t  mcfg,
	output wss_pkg::win_t   win,
	output logic            all_ok
);
	import wss_pkg::*;

	logic [WINDOW-1:0][7:0] cell_byte;
	logic [WINDOW-1:0]      cell_ok;

	// Cells, each fed by its younger neighbour.
	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign win[g] = data_byte;
		end else begin : g_body
			assign win[g] = cell_byte[g-1];
		end

		wss_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.age     (AGE_W'(g)),
			.mcfg    (mcfg),
			.byte_in (win[g]),
			.byte_q  (cell_byte[g]),
			.ok      (cell_ok[g])
		);
	end

	// The pattern matches when every cell agrees.
	assign all_ok = &cell_ok;

endmodule

FILE: sv/wildcard_signature_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_signature_scanner: streaming wildcard byte-pattern search
// Keeps a sliding window of image bytes in a row of cells and reports the
// first start position where the masked pattern matches.
// ----------------------------------------------------------------------------
// The scanner takes one image byte per clock cycle, back to back, when not
// stalled, with no clearing pass after reset. Each byte shifts into a 32-cell
// window; every cell compares the byte it takes with the pattern byte aligned
// to it, so a start position is tested in the same cycle as the byte that
// completes its span (the pattern length, or in pointer mode the pointer
// offset plus four if that is longer). Each result is registered in a single
// output register; a new byte is taken while that result is being handed on.
// Only the first match of an image gives a result; bytes after it are dropped
// until the last byte. If nothing matches, a not-found result travels with
// the last byte. The last byte always ends the scan and the next byte starts
// a new one at position zero. Configuration registers are meant to be
// written between transactions, not while a result is pending.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration writes
	input  logic                           cfg_write,
	input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data,
	// Image byte stream
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	// Results
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           status,
	output logic [31:0]                    value
);
	import wss_pkg::*;

	// Configuration registers.
	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [15:0] care_mask_q;
	logic [4:0]  pattern_length_q;
	logic        return_mode_q;
	logic [4:0]  pointer_offset_q;
	logic [15:0] address_adjust_q;
	logic [31:0] image_base_q;

	// Scan state.
	logic [SPAN_W-1:0] fill_q;
	logic [31:0]       pos_q;
	logic              match_reported_q;

	// Output register.
	logic        result_valid_q;
	logic        status_q;
	logic [31:0] value_q;

	// Derived settings and datapath.
	mcfg_t             mcfg;
	logic [LEN_W-1:0]  eff_len;
	logic [SPAN_W-1:0] eff_off;
	logic [SPAN_W-1:0] span;
	win_t              win;
	logic              all_ok;
	logic              accept;
	logic              shift;
	logic [SPAN_W-1:0] fill_next;
	logic              hit;
	logic              produce;
	logic [31:0]       ptr_word;
	logic [31:0]       addr_value;
	logic [SPAN_W-1:0] word_age [4];

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= 5'd1;
			return_mode_q    <= MODE_POINTER;
			pointer_offset_q <= '0;
			address_adjust_q <= '0;
			image_base_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_CARE_MASK:      care_mask_q      <= cfg_data[15:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				REG_RETURN_MODE:    return_mode_q    <= cfg_data[0];
				REG_POINTER_OFFSET: pointer_offset_q <= cfg_data[4:0];
				REG_ADDRESS_ADJUST: address_adjust_q <= cfg_data[15:0];
				REG_IMAGE_BASE:     image_base_q     <= cfg_data[31:0];
			endcase
		end
	end

	// Effective length, offset and span, with out-of-range values saturated.
	always_comb begin
		if (pattern_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(pattern_length_q) > MAX_LEN) begin
			eff_len = LEN_W'(MAX_LEN);
		end else begin
			eff_len = LEN_W'(pattern_length_q);
		end

		if (int'(pointer_offset_q) > WINDOW - 4) begin
			eff_off = SPAN_W'(WINDOW - 4);
		end else begin
			eff_off = SPAN_W'(pointer_offset_q);
		end

		if (return_mode_q == MODE_POINTER && (eff_off + SPAN_W'(4)) > SPAN_W'(eff_len)) begin
			span = eff_off + SPAN_W'(4);
		end else begin
			span = SPAN_W'(eff_len);
		end
	end

	// Pattern bytes and care bits; bytes beyond the registers are wildcards.
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			if (i < 8) begin
				mcfg.pattern[i] = pattern_low_q[8*i +: 8];
				mcfg.care[i]    = care_mask_q[i];
			end else if (i < PAT_REG_BYTES) begin
				mcfg.pattern[i] = pattern_high_q[8*(i-8) +: 8];
				mcfg.care[i]    = care_mask_q[i];
			end else begin
				mcfg.pattern[i] = 8'd0;
				mcfg.care[i]    = 1'b0;
			end
		end
		mcfg.len  = eff_len;
		mcfg.span = span;
	end

	// Window of cells.
	wss_chain u_chain (
		.clk       (clk),
		.shift     (shift),
		.data_byte (data_byte),
		.mcfg      (mcfg),
		.win       (win),
		.all_ok    (all_ok)
	);

	// Handshake: take a byte unless a held result cannot leave this cycle.
	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign shift      = accept && !match_reported_q;

	// Match test once the window holds the whole span.
	always_comb begin
		if (fill_q == SPAN_W'(WINDOW)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + SPAN_W'(1);
		end
		hit     = all_ok && (fill_next >= span);
		produce = shift && (hit || last_byte);
	end

	// Little-endian pointer word taken from the post-shift window.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			word_age[i] = span - SPAN_W'(1) - eff_off - SPAN_W'(i);
		end
		ptr_word = {win[word_age[3][AGE_W-1:0]], win[word_age[2][AGE_W-1:0]],
			win[word_age[1][AGE_W-1:0]], win[word_age[0][AGE_W-1:0]]};
	end

	// Match address: base + start position + signed adjust, modulo 2^32.
	assign addr_value = image_base_q + {{16{address_adjust_q[15]}}, address_adjust_q}
		+ pos_q + 32'd1 - 32'(span);

	// Scan state: position, fill level and the reported flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q           <= '0;
			pos_q            <= '0;
			match_reported_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				fill_q           <= '0;
				pos_q            <= '0;
				match_reported_q <= 1'b0;
			end else if (!match_reported_q) begin
				fill_q           <= fill_next;
				pos_q            <= pos_q + 32'd1;
				match_reported_q <= hit;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (produce) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (produce) begin
			if (hit) begin
				status_q <= STATUS_FOUND;
				value_q  <= (return_mode_q == MODE_ADDRESS) ? addr_value : ptr_word;
			end else begin
				status_q <= STATUS_NOT_FOUND;
				value_q  <= 32'd0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign value        = value_q;

endmodule
